[sv/ipv4_longest_prefix_route_lookup_defines.svh]
// Assertion macros for the IPv4 route lookup block.
// Used by the top level only; relies on clk and rst_n being in scope.
`ifndef IPV4_LONGEST_PREFIX_ROUTE_LOOKUP_DEFINES_SVH
`define IPV4_LONGEST_PREFIX_ROUTE_LOOKUP_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define LPM_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define LPM_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

[sv/lpm_pkg.sv]
// Shared types, codes and helpers for the IPv4 route lookup block.
// No dependencies.
package lpm_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int ADDR_W   = 32;
  localparam int PREFIX_W = 6;
  localparam int IFACE_W  = 4;
  localparam logic [PREFIX_W-1:0] MAX_PREFIX = 6'd32;
  localparam logic [ADDR_W-1:0]   FULL_MASK  = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ROUTE = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // One request travelling down the cell row. For an add, net/prefix/hop/iface
  // carry the route to store; for a lookup they carry the best match so far.
  typedef struct packed {
    logic                valid;
    op_t                 op;
    status_t             status;
    logic                found;
    logic [ADDR_W-1:0]   dest;
    logic [ADDR_W-1:0]   net;
    logic [PREFIX_W-1:0] prefix;
    logic [ADDR_W-1:0]   hop;
    logic [IFACE_W-1:0]  iface;
  } token_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] plen);
    logic [ADDR_W-1:0] m;
    if (plen > MAX_PREFIX) begin
      m = FULL_MASK;
    end else begin
      m = ~(FULL_MASK >> plen);
    end
    return m;
  endfunction

endpackage

[sv/ipv4_longest_prefix_route_lookup.sv]
// IPv4 longest-prefix route table built as a row of TABLE_DEPTH cells, one route per cell.
// Every request (add or lookup) enters the row and steps one cell per cycle, so the block
// takes one request per cycle, holding the whole row while the result is not taken. Each
// request passes the cell registers in turn and then the result register; results leave
// in order. A lookup picks up the longest matching prefix on its way, the earliest added
// route winning a tie. An add goes into the first free cell; a prefix above 32 gives
// status 1 (no route), a full table status 2, and an add always returns zero match fields.
// Depends on lpm_pkg, lpm_cell, lpm_out and ipv4_longest_prefix_route_lookup_defines.svh.
`include "ipv4_longest_prefix_route_lookup_defines.svh"

module ipv4_longest_prefix_route_lookup import lpm_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // route_address[31:0], route_prefix[37:32], route_next_hop[69:38],
  // route_interface[73:70], lookup_address[105:74], zero fill [111:106]
  input  logic [111:0] in_tdata,
  // opcode[0]
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // match_network[31:0], match_prefix[37:32], match_next_hop[69:38],
  // match_interface[73:70], zero fill [79:74]
  output logic [79:0]  out_tdata,
  // status[1:0]
  output logic [1:0]   out_tuser
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

  logic                adv;
  logic                in_acc;
  op_t                 in_op;
  logic [ADDR_W-1:0]   in_addr;
  logic [PREFIX_W-1:0] in_prefix;
  logic [ADDR_W-1:0]   in_hop;
  logic [IFACE_W-1:0]  in_iface;
  logic [ADDR_W-1:0]   in_dest;

  logic [CW-1:0] count_r, count_nxt;
  status_t       add_status;
  token_t        head_tok;

  token_t        tok [0:TABLE_DEPTH];
  logic [CW-1:0] cnt [0:TABLE_DEPTH];

  logic [ADDR_W-1:0]   res_net;
  logic [PREFIX_W-1:0] res_prefix;
  logic [ADDR_W-1:0]   res_hop;
  logic [IFACE_W-1:0]  res_iface;

  logic                add_to_full;
  logic                out_failed;

  // Advance the whole row whenever the result slot is free or being taken.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && in_tready;

  assign in_op     = op_t'(in_tuser[0]);
  assign in_addr   = in_tdata[31:0];
  assign in_prefix = in_tdata[37:32];
  assign in_hop    = in_tdata[69:38];
  assign in_iface  = in_tdata[73:70];
  assign in_dest   = in_tdata[105:74];

  always_comb begin
    if (in_prefix > MAX_PREFIX) begin
      add_status = ST_NO_ROUTE;
    end else if (count_r == DEPTH_CNT) begin
      add_status = ST_FULL;
    end else begin
      add_status = ST_OK;
    end
  end

  always_comb begin
    head_tok       = '0;
    head_tok.valid = in_tvalid;
    head_tok.op    = in_op;
    head_tok.dest  = in_dest;
    if (in_op == OP_ADD) begin
      head_tok.status = add_status;
      head_tok.net    = in_addr & prefix_mask(in_prefix);
      head_tok.prefix = in_prefix;
      head_tok.hop    = in_hop;
      head_tok.iface  = in_iface;
    end else begin
      head_tok.status = ST_OK;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (in_acc && (in_op == OP_ADD) && (add_status == ST_OK)) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Each request carries the fill count as it stood when it was accepted.
  assign tok[0] = head_tok;
  assign cnt[0] = count_r;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    lpm_cell #(
      .CW    (CW),
      .INDEX (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (tok[k]),
      .cnt_i (cnt[k]),
      .tok_o (tok[k+1]),
      .cnt_o (cnt[k+1])
    );
  end

  lpm_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .tok_i      (tok[TABLE_DEPTH]),
    .out_tvalid (out_tvalid),
    .status_o   (out_tuser),
    .network_o  (res_net),
    .prefix_o   (res_prefix),
    .hop_o      (res_hop),
    .iface_o    (res_iface)
  );

  assign out_tdata = {6'd0, res_iface, res_hop, res_prefix, res_net};

  assign add_to_full = in_acc && (in_op == OP_ADD) && (count_r == DEPTH_CNT);
  assign out_failed  = out_tvalid && (out_tuser != ST_OK);

  `LPM_ASSERT_IMP(a_count_bound, 1'b1, count_r <= DEPTH_CNT, "fill count beyond table depth")
  `LPM_ASSERT_NEXT(a_full_drop, add_to_full, $stable(count_r), "add to full table moved count")
  `LPM_ASSERT_IMP(a_no_route_zero, out_failed, out_tdata == '0, "failed request has match data")

endmodule

[sv/lpm_cell.sv]
// One route table cell: holds a single entry and compares passing lookups.
// Depends on lpm_pkg.
module lpm_cell import lpm_pkg::*; #(
  parameter int CW    = 5,
  parameter int INDEX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  token_t        tok_i,
  input  logic [CW-1:0] cnt_i,
  output token_t        tok_o,
  output logic [CW-1:0] cnt_o
);

  localparam logic [CW-1:0] SLOT = CW'(INDEX);

  logic [ADDR_W-1:0]   net_r;
  logic [PREFIX_W-1:0] prefix_r;
  logic [ADDR_W-1:0]   hop_r;
  logic [IFACE_W-1:0]  iface_r;

  token_t        tok_r, tok_nxt;
  logic [CW-1:0] cnt_r;
  logic          wr_en;
  logic          hit;

  assign wr_en = adv && tok_i.valid && (tok_i.op == OP_ADD) &&
                 (tok_i.status == ST_OK) && (cnt_i == SLOT);

  // Only entries below the fill count seen by this request take part.
  assign hit = tok_i.valid && (tok_i.op == OP_LOOKUP) && (SLOT < cnt_i) &&
               ((tok_i.dest & prefix_mask(prefix_r)) == net_r) &&
               (!tok_i.found || (prefix_r > tok_i.prefix));

  always_comb begin
    tok_nxt = tok_i;
    if (hit) begin
      tok_nxt.found  = 1'b1;
      tok_nxt.net    = net_r;
      tok_nxt.prefix = prefix_r;
      tok_nxt.hop    = hop_r;
      tok_nxt.iface  = iface_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      net_r    <= tok_i.net;
      prefix_r <= tok_i.prefix;
      hop_r    <= tok_i.hop;
      iface_r  <= tok_i.iface;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      cnt_r <= '0;
    end else if (adv) begin
      tok_r <= tok_nxt;
      cnt_r <= cnt_i;
    end
  end

  assign tok_o = tok_r;
  assign cnt_o = cnt_r;

endmodule

[sv/lpm_out.sv]
// Result register: turns the request leaving the cell row into a result.
// Depends on lpm_pkg.
module lpm_out import lpm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  token_t       tok_i,
  output logic         out_tvalid,
  output logic [1:0]   status_o,
  output logic [ADDR_W-1:0]   network_o,
  output logic [PREFIX_W-1:0] prefix_o,
  output logic [ADDR_W-1:0]   hop_o,
  output logic [IFACE_W-1:0]  iface_o
);

  logic                valid_r;
  status_t             status_r, status_nxt;
  logic [ADDR_W-1:0]   net_r, net_nxt;
  logic [PREFIX_W-1:0] prefix_r, prefix_nxt;
  logic [ADDR_W-1:0]   hop_r, hop_nxt;
  logic [IFACE_W-1:0]  iface_r, iface_nxt;
  logic                show;

  assign show = (tok_i.op == OP_LOOKUP) && tok_i.found;

  always_comb begin
    if (tok_i.op == OP_ADD) begin
      status_nxt = tok_i.status;
    end else if (tok_i.found) begin
      status_nxt = ST_OK;
    end else begin
      status_nxt = ST_NO_ROUTE;
    end
    net_nxt    = show ? tok_i.net    : '0;
    prefix_nxt = show ? tok_i.prefix : '0;
    hop_nxt    = show ? tok_i.hop    : '0;
    iface_nxt  = show ? tok_i.iface  : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= tok_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= status_nxt;
      net_r    <= net_nxt;
      prefix_r <= prefix_nxt;
      hop_r    <= hop_nxt;
      iface_r  <= iface_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign status_o   = status_r;
  assign network_o  = net_r;
  assign prefix_o   = prefix_r;
  assign hop_o      = hop_r;
  assign iface_o    = iface_r;

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for the IPv4 longest-prefix route lookup: a directed table of requests,
// then random adds and lookups, each result compared with a local route table model.
// Depends on lpm_pkg and the ipv4_longest_prefix_route_lookup top level.
module tb_top import lpm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = DEFAULT_TABLE_DEPTH;
  localparam int N_RANDOM   = 1300;
  localparam int N_DIRECTED = 28;
  localparam int HOLD_AT    = 500;
  localparam int HOLD_LEN   = 150;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   net;
    logic [PREFIX_W-1:0] prefix;
    logic [ADDR_W-1:0]   hop;
    logic [IFACE_W-1:0]  iface;
  } route_result_t;

  // typed rows expect the given status with every match field zero
  typedef struct packed {
    op_t                 op;
    logic [ADDR_W-1:0]   raddr;
    logic [PREFIX_W-1:0] rpref;
    logic [ADDR_W-1:0]   rhop;
    logic [IFACE_W-1:0]  riface;
    logic [ADDR_W-1:0]   dest;
    logic                typed;
    status_t             st;
  } stim_row_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata   = '0;
  logic [0:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [79:0]  out_tdata;
  logic [1:0]   out_tuser;

  // local copy of the route table
  logic [ADDR_W-1:0]   rt_net    [DEPTH];
  logic [PREFIX_W-1:0] rt_prefix [DEPTH];
  logic [ADDR_W-1:0]   rt_hop    [DEPTH];
  logic [IFACE_W-1:0]  rt_iface  [DEPTH];
  int                  rt_count = 0;

  route_result_t expected_routes [$];
  int            fail_count   = 0;
  int            results_seen = 0;
  stim_row_t     dir_rows [N_DIRECTED];

  ipv4_longest_prefix_route_lookup #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Worst run: ~1330 requests, each with the longest send gap, the longest result stall and
  // the row latency, plus the long hold-off: roughly 1 ms. Allow six.
  initial begin
    #6_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] net_mask(input logic [PREFIX_W-1:0] plen);
    logic [ADDR_W-1:0] m;
    if (plen == 0) begin
      m = '0;
    end else if (plen > 6'd32) begin
      m = '1;
    end else begin
      m = 32'hFFFF_FFFF << (32 - plen);
    end
    return m;
  endfunction

  function automatic route_result_t route_table_apply(input op_t op,
      input logic [ADDR_W-1:0] raddr, input logic [PREFIX_W-1:0] rpref,
      input logic [ADDR_W-1:0] rhop, input logic [IFACE_W-1:0] riface,
      input logic [ADDR_W-1:0] dest);
    route_result_t r;
    int            best;
    int            i;
    r      = '0;
    r.status = ST_OK;
    best   = -1;
    if (op == OP_ADD) begin
      if (rpref > 6'd32) begin
        r.status = ST_NO_ROUTE;
      end else if (rt_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        rt_net[rt_count]    = raddr & net_mask(rpref);
        rt_prefix[rt_count] = rpref;
        rt_hop[rt_count]    = rhop;
        rt_iface[rt_count]  = riface;
        rt_count++;
      end
    end else begin
      // strict compare keeps the earliest route on a tie
      for (i = 0; i < rt_count; i++) begin
        if ((dest & net_mask(rt_prefix[i])) == rt_net[i] &&
            (best < 0 || rt_prefix[i] > rt_prefix[best])) begin
          best = i;
        end
      end
      if (best < 0) begin
        r.status = ST_NO_ROUTE;
      end else begin
        r.net    = rt_net[best];
        r.prefix = rt_prefix[best];
        r.hop    = rt_hop[best];
        r.iface  = rt_iface[best];
      end
    end
    return r;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int roll;
    int g;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 75) begin
      g = 0;
    end else if (roll < 95) begin
      g = $urandom_range(1, 3);
    end else begin
      g = $urandom_range(8, 40);
    end
    return g;
  endfunction

  task automatic send_request(input op_t op, input logic [ADDR_W-1:0] raddr,
      input logic [PREFIX_W-1:0] rpref, input logic [ADDR_W-1:0] rhop,
      input logic [IFACE_W-1:0] riface, input logic [ADDR_W-1:0] dest,
      input logic typed, input status_t typed_status);
    route_result_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {6'd0, dest, riface, rhop, rpref, raddr};
    do @(posedge clk); while (!in_tready);
    predicted = route_table_apply(op, raddr, rpref, rhop, riface, dest);
    if (typed) begin
      predicted        = '0;
      predicted.status = typed_status;
    end
    expected_routes = {expected_routes, predicted};
  endtask

  task automatic sender_gap(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, name, exp, act);
    end
  endtask

  // result side: check every accepted result, stall at random, hold off once for a long stretch
  initial begin
    route_result_t exp_r;
    int            wait_left;
    bit            held;
    wait_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        results_seen++;
        if (expected_routes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual status %0d net 0x%08h",
                   $time, out_tuser, out_tdata[31:0]);
        end else begin
          exp_r = expected_routes.pop_front();
          check_field("status", 32'(exp_r.status), 32'(out_tuser));
          check_field("match_network", exp_r.net, out_tdata[31:0]);
          check_field("match_prefix", 32'(exp_r.prefix), 32'(out_tdata[37:32]));
          check_field("match_next_hop", exp_r.hop, out_tdata[69:38]);
          check_field("match_interface", 32'(exp_r.iface), 32'(out_tdata[73:70]));
        end
      end
      if (!held && results_seen >= HOLD_AT) begin
        held      = 1'b1;
        wait_left = HOLD_LEN;
      end
      if (wait_left > 0) begin
        out_tready <= 1'b0;
        wait_left--;
      end else begin
        out_tready <= 1'b1;
        wait_left = pick_gap(((results_seen / 128) % 3) == 0);
      end
    end
  end

  initial begin
    op_t                 op;
    logic [ADDR_W-1:0]   raddr;
    logic [PREFIX_W-1:0] rpref;
    logic [ADDR_W-1:0]   rhop;
    logic [IFACE_W-1:0]  riface;
    logic [ADDR_W-1:0]   dest;
    int                  k;
    int                  roll;
    int                  n;

    dir_rows = '{
      // empty table, route fields set but ignored
      '{OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 4'hF, 32'h0000_0000, 1'b1, ST_NO_ROUTE},
      // prefix above 32 is rejected
      '{OP_ADD,    32'h1234_5678, 6'd33, 32'h0000_0001, 4'h1, 32'h0000_0000, 1'b1, ST_NO_ROUTE},
      '{OP_ADD,    32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 1'b1, ST_NO_ROUTE},
      '{OP_ADD,    32'h0A00_0000, 6'd8,  32'h0A00_0001, 4'h1, 32'hFFFF_FFFF, 1'b1, ST_OK},
      '{OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0000_0000, 4'h0, 32'h0B00_0000, 1'b0, ST_OK},
      '{OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0000_0000, 4'h0, 32'h0A7F_FFFF, 1'b0, ST_OK},
      // default route
      '{OP_ADD,    32'hFFFF_FFFF, 6'd0,  32'hFFFF_FFFF, 4'hF, 32'h0000_0000, 1'b1, ST_OK},
      // two equal prefixes over the same network, the first must win
      '{OP_ADD,    32'h0A01_02FF, 6'd24, 32'h0A01_0201, 4'h2, 32'h0000_0000, 1'b1, ST_OK},
      '{OP_ADD,    32'h0A01_0200, 6'd24, 32'h0A01_02FE, 4'h3, 32'h0000_0000, 1'b1, ST_OK},
      '{OP_ADD,    32'h0A01_0203, 6'd32, 32'h0000_0000, 4'h0, 32'h0000_0000, 1'b1, ST_OK},
      '{OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0000_0000, 4'h0, 32'h0A01_0203, 1'b0, ST_OK},
      '{OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0000_0000, 4'h0, 32'h0A01_02AA, 1'b0, ST_OK},
      '{OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0000_0000, 4'h0, 32'h0B00_0000, 1'b0, ST_OK},
      '{OP_ADD,    32'hC0A8_0000, 6'd16, 32'hC0A8_0001, 4'h4, 32'h0000_0000, 1'b1, ST_OK},
      '{OP_ADD,    32'hC0A8_0180, 6'd23, 32'hC0A8_01FE, 4'h5, 32'h0000_0000, 1'b1, ST_OK},
      '{OP_ADD,    32'hAC10_0000, 6'd12, 32'hAC10_0001, 4'h6, 32'h0000_0000, 1'b1, ST_OK},
      '{OP_ADD,    32'h7F00_0001, 6'd8,  32'h7F00_0001, 4'h7, 32'h0000_0000, 1'b1, ST_OK},
      '{OP_ADD,    32'hE000_0000, 6'd4,  32'hE000_0001, 4'h8, 32'h0000_0000, 1'b1, ST_OK},
      '{OP_ADD,    32'h0A80_0000, 6'd9,  32'h0A80_0001, 4'h9, 32'h0000_0000, 1'b1, ST_OK},
      '{OP_ADD,    32'h0A01_0000, 6'd16, 32'h0A01_0001, 4'hA, 32'h0000_0000, 1'b1, ST_OK},
      '{OP_ADD,    32'hFFFF_FFFE, 6'd31, 32'hFFFF_FFFF, 4'hB, 32'h0000_0000, 1'b1, ST_OK},
      '{OP_ADD,    32'h0A01_0200, 6'd25, 32'h0A01_0280, 4'hC, 32'h0000_0000, 1'b1, ST_OK},
      '{OP_ADD,    32'h0102_0304, 6'd30, 32'h0102_0301, 4'hD, 32'h0000_0000, 1'b1, ST_OK},
      '{OP_ADD,    32'h0A01_02FF, 6'd32, 32'h0A01_02FF, 4'hE, 32'h0000_0000, 1'b1, ST_OK},
      // table now full: drop the route; a bad prefix still reports no route
      '{OP_ADD,    32'h0808_0808, 6'd32, 32'h0808_0808, 4'h5, 32'h0000_0000, 1'b1, ST_FULL},
      '{OP_ADD,    32'h0808_0808, 6'd40, 32'h0808_0808, 4'h5, 32'h0000_0000, 1'b1, ST_NO_ROUTE},
      '{OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0000_0000, 4'h0, 32'h0A01_0210, 1'b0, ST_OK},
      '{OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0000_0000, 4'h0, 32'hFFFF_FFFF, 1'b0, ST_OK}
    };

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    for (n = 0; n < N_DIRECTED; n++) begin
      send_request(dir_rows[n].op, dir_rows[n].raddr, dir_rows[n].rpref, dir_rows[n].rhop,
                   dir_rows[n].riface, dir_rows[n].dest, dir_rows[n].typed, dir_rows[n].st);
      sender_gap(pick_gap(1'b0));
    end

    for (n = 0; n < N_RANDOM; n++) begin
      // pause until the row has drained, twice in the run
      if (n == 0 || n == N_RANDOM / 2) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_routes.size() != 0) @(posedge clk);
      end
      raddr  = $urandom;
      rhop   = $urandom;
      riface = IFACE_W'($urandom_range(0, 15));
      rpref  = ($urandom_range(0, 3) == 0) ? PREFIX_W'($urandom_range(33, 63))
                                           : PREFIX_W'($urandom_range(0, 32));
      dest   = $urandom;
      roll   = $urandom_range(0, 99);
      if (roll < 12) begin
        op = OP_ADD;
      end else begin
        op = OP_LOOKUP;
        // aim most lookups inside a stored route, some one bit off it
        if (roll < 85 && rt_count > 0) begin
          k    = $urandom_range(0, rt_count - 1);
          dest = rt_net[k] | (dest & ~net_mask(rt_prefix[k]));
          if (roll >= 75) begin
            dest = dest ^ (32'h1 << $urandom_range(0, 31));
          end
        end
      end
      send_request(op, raddr, rpref, rhop, riface, dest, 1'b0, ST_OK);
      sender_gap(pick_gap(((n / 64) % 3) == 0));
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (4 * DEPTH) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
